// ----- rtl/core/dwsp_pkg.sv -----
// Shared types, widths and register codes of the dual wheel speed PI drive.
package dwsp_pkg;

   // Fixed point: speeds and accumulators carry FRAC_BITS fractional bits.
   localparam int FRAC_BITS = 8;
   localparam int DEADBAND  = 5;
   localparam int FRAC_UP   = (FRAC_BITS > 8) ? (FRAC_BITS - 8) : 0;
   localparam int FRAC_DN   = (FRAC_BITS < 8) ? (8 - FRAC_BITS) : 0;

   localparam int COUNT_W = 32;
   localparam int FILT_W  = 32;
   localparam int SPEED_W = 24;
   localparam int TGT_W   = 16;
   localparam int ERR_W   = 25;
   localparam int ACC_W   = 16 + FRAC_BITS;
   localparam int CTL_W   = 16;
   localparam int DUTY_W  = 16;
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Configuration port.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam logic [2:0] REG_FILTER_ALPHA = 3'd0;
   localparam logic [2:0] REG_SPEED_SCALE  = 3'd1;
   localparam logic [2:0] REG_KI_LEFT      = 3'd2;
   localparam logic [2:0] REG_KP_LEFT      = 3'd3;
   localparam logic [2:0] REG_KI_RIGHT     = 3'd4;
   localparam logic [2:0] REG_KP_RIGHT     = 3'd5;
   localparam logic [2:0] REG_MAX_PWM      = 3'd6;

   // Sequencer steps shared by both lanes.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DELTA,
      ST_RAW,
      ST_AMUL,
      ST_BMUL,
      ST_FILT,
      ST_SPEED,
      ST_ERR,
      ST_IMUL,
      ST_PMUL,
      ST_INC,
      ST_ACC,
      ST_CTL,
      ST_OUT
   } step_type;

   typedef struct packed {
      logic [8:0]  alpha;
      logic [15:0] scale;
      logic [15:0] ki;
      logic [15:0] kp;
      logic [14:0] max_pwm;
   } lane_cfg_type;

   typedef struct packed {
      logic                      command;
      logic signed [COUNT_W-1:0] left_enc;
      logic signed [COUNT_W-1:0] right_enc;
      logic signed [TGT_W-1:0]   target;
      logic signed [15:0]        base_or_offset;
   } req_type;

   typedef struct packed {
      logic                      left_forward;
      logic [DUTY_W-1:0]         left_duty;
      logic                      right_forward;
      logic [DUTY_W-1:0]         right_duty;
      logic signed [SPEED_W-1:0] left_speed_now;
      logic signed [SPEED_W-1:0] right_speed_now;
   } rsp_type;

endpackage

// ----- rtl/core/dwsp_lane.sv -----
// One wheel lane: count delta, speed scaling, filter and incremental PI controller.
module dwsp_lane import dwsp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  step_type                  step,
   input  logic [COUNT_W-1:0]        count,
   input  logic signed [TGT_W-1:0]   target,
   input  lane_cfg_type              cfg,
   output logic signed [SPEED_W-1:0] speed_now,
   output logic signed [CTL_W-1:0]   control
);

   localparam int RAWQ_W = MUL_P_W + FRAC_UP;
   localparam int PSUM_W = MUL_P_W + 1;
   localparam int INC_W  = PSUM_W + FRAC_UP;
   localparam int SUM_W  = INC_W + 1;
   localparam int DIFF_W = ERR_W + 1;

   localparam logic signed [RAWQ_W-1:0] RAW_MAX    = RAWQ_W'(64'sh7FFF_FFFF);
   localparam logic signed [RAWQ_W-1:0] RAW_MIN    = ~RAW_MAX;
   localparam logic signed [FILT_W:0]   SPD_MAX    = (FILT_W+1)'(64'sh7F_FFFF);
   localparam logic signed [FILT_W:0]   SPD_MIN    = ~SPD_MAX;
   localparam logic signed [FILT_W:0]   FILT_ADJ   = (FILT_W+1)'((1 << FRAC_BITS) - 1);
   localparam logic signed [ACC_W:0]    ACC_ADJ    = (ACC_W+1)'((1 << FRAC_BITS) - 1);
   localparam logic [8:0]               ALPHA_FULL = 9'd256;

   // Wheel state kept from tick to tick.
   logic [COUNT_W-1:0]       prev_ff, prev_in;
   logic signed [FILT_W-1:0] filt_ff, filt_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ERR_W-1:0]  perr_ff, perr_in;

   // Working registers of the sequence.
   logic signed [MUL_P_W-1:0] prod_ff, prod_in;
   logic signed [MUL_P_W-1:0] sum_ff, sum_in;
   logic signed [FILT_W-1:0]  raw_ff, raw_in;
   logic signed [SPEED_W-1:0] speed_ff, speed_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [INC_W-1:0]   inc_ff, inc_in;
   logic signed [CTL_W-1:0]   ctl_ff, ctl_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [COUNT_W-1:0] delta;
   logic signed [DIFF_W-1:0]  err_diff;
   logic [8:0]                alpha_eff;
   logic [8:0]                alpha_inv;

   logic signed [RAWQ_W-1:0]  rawq;
   logic signed [PSUM_W-1:0]  psum;
   logic signed [FILT_W:0]    tsum;
   logic signed [FILT_W:0]    tq;
   logic signed [INC_W-1:0]   incq;
   logic signed [SUM_W-1:0]   asum;
   logic signed [SUM_W-1:0]   lim;
   logic signed [ACC_W:0]     csum;

   // Filter weight above full scale counts as full scale.
   assign alpha_eff = cfg.alpha[8] ? ALPHA_FULL : cfg.alpha;
   assign alpha_inv = ALPHA_FULL - alpha_eff;
   assign delta     = count - prev_ff;
   assign err_diff  = DIFF_W'(err_ff) - DIFF_W'(perr_ff);

   // Multiplier operand selection for each step.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step)
         ST_DELTA: begin
            mul_a = MUL_A_W'(delta);
            mul_b = MUL_B_W'(cfg.scale);
         end
         ST_AMUL: begin
            mul_a = MUL_A_W'(raw_ff);
            mul_b = MUL_B_W'(alpha_eff);
         end
         ST_BMUL: begin
            mul_a = MUL_A_W'(filt_ff);
            mul_b = MUL_B_W'(alpha_inv);
         end
         ST_IMUL: begin
            mul_a = MUL_A_W'(err_diff);
            mul_b = MUL_B_W'(cfg.ki);
         end
         ST_PMUL: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = MUL_B_W'(cfg.kp);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Datapath arithmetic shared by the steps.
   always_comb begin
      rawq = (RAWQ_W'(prod_ff) <<< FRAC_UP) >>> FRAC_DN;
      psum = PSUM_W'(sum_ff) + PSUM_W'(prod_ff);
      tsum = (FILT_W+1)'(filt_ff) + ((filt_ff < 0) ? FILT_ADJ : '0);
      tq   = tsum >>> FRAC_BITS;
      incq = (INC_W'(psum) <<< FRAC_UP) >>> FRAC_DN;
      asum = SUM_W'(acc_ff) + SUM_W'(inc_ff);
      lim  = SUM_W'(cfg.max_pwm) << FRAC_BITS;
      csum = (ACC_W+1)'(acc_ff) + ((acc_ff < 0) ? ACC_ADJ : '0);
   end

   // Next values: the product loads each step, other registers only in their own.
   always_comb begin
      prev_in  = prev_ff;
      filt_in  = filt_ff;
      acc_in   = acc_ff;
      perr_in  = perr_ff;
      prod_in  = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
      sum_in   = sum_ff;
      raw_in   = raw_ff;
      speed_in = speed_ff;
      err_in   = err_ff;
      inc_in   = inc_ff;
      ctl_in   = ctl_ff;
      case (step)
         ST_DELTA: begin
            prev_in = count;
         end
         ST_RAW: begin
            if (rawq > RAW_MAX) begin
               raw_in = RAW_MAX[FILT_W-1:0];
            end else if (rawq < RAW_MIN) begin
               raw_in = RAW_MIN[FILT_W-1:0];
            end else begin
               raw_in = rawq[FILT_W-1:0];
            end
         end
         ST_BMUL: begin
            sum_in = prod_ff;
         end
         ST_FILT: begin
            // A weighted mean of two 32-bit values stays in 32 bits.
            filt_in = psum[FILT_W+7:8];
         end
         ST_SPEED: begin
            if (tq > SPD_MAX) begin
               speed_in = SPD_MAX[SPEED_W-1:0];
            end else if (tq < SPD_MIN) begin
               speed_in = SPD_MIN[SPEED_W-1:0];
            end else begin
               speed_in = tq[SPEED_W-1:0];
            end
         end
         ST_ERR: begin
            err_in = ERR_W'(target) - ERR_W'(speed_ff);
         end
         ST_PMUL: begin
            sum_in  = prod_ff;
            perr_in = err_ff;
         end
         ST_INC: begin
            inc_in = incq;
         end
         ST_ACC: begin
            if (asum > lim) begin
               acc_in = ACC_W'(lim);
            end else if (asum < -lim) begin
               acc_in = ACC_W'(-lim);
            end else begin
               acc_in = ACC_W'(asum);
            end
         end
         ST_CTL: begin
            ctl_in = CTL_W'(csum >>> FRAC_BITS);
         end
         default: begin
            prev_in = prev_ff;
         end
      endcase
   end

   // Wheel state clears at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         filt_ff <= '0;
         acc_ff  <= '0;
         perr_ff <= '0;
      end else begin
         prev_ff <= prev_in;
         filt_ff <= filt_in;
         acc_ff  <= acc_in;
         perr_ff <= perr_in;
      end
   end

   // Working registers need no reset.
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      sum_ff   <= sum_in;
      raw_ff   <= raw_in;
      speed_ff <= speed_in;
      err_ff   <= err_in;
      inc_ff   <= inc_in;
      ctl_ff   <= ctl_in;
   end

   assign speed_now = speed_ff;
   assign control   = ctl_ff;

endmodule

// ----- rtl/core/dwsp_merge.sv -----
// Merging stage: turns both lane controls into directions and duties.
module dwsp_merge import dwsp_pkg::*; (
   input  logic                      command,
   input  logic signed [15:0]        base_or_offset,
   input  logic signed [SPEED_W-1:0] left_spd,
   input  logic signed [SPEED_W-1:0] right_spd,
   input  logic signed [CTL_W-1:0]   left_ctl,
   input  logic signed [CTL_W-1:0]   right_ctl,
   output rsp_type                   rsp
);

   // Magnitude saturated to the duty range.
   function automatic logic [DUTY_W-1:0] mag16(input logic signed [17:0] v);
      logic [17:0] a;
      a = (v < 0) ? 18'(-v) : 18'(v);
      return (a > 18'd65535) ? 16'hFFFF : a[DUTY_W-1:0];
   endfunction

   logic signed [17:0] left_drive;
   logic signed [17:0] right_drive;
   logic signed [17:0] turn_drive;
   logic signed [17:0] right_abs;

   always_comb begin
      left_drive  = 18'(base_or_offset) - 18'(left_ctl);
      right_drive = 18'(base_or_offset) + 18'(right_ctl);
      right_abs   = (right_ctl < 0) ? -18'(right_ctl) : 18'(right_ctl);
      turn_drive  = 18'(base_or_offset) + right_abs;
   end

   // Pivot turn holds the left wheel; speed mode drives both around the base.
   always_comb begin
      rsp.left_speed_now  = left_spd;
      rsp.right_speed_now = right_spd;
      if (command) begin
         rsp.left_forward  = (left_ctl > 0);
         rsp.left_duty     = '0;
         rsp.right_forward = (right_ctl > 0);
         rsp.right_duty    = (turn_drive < 0) ? '0 : mag16(turn_drive);
      end else begin
         rsp.left_forward  = (left_drive >= 0);
         rsp.left_duty     = mag16(left_drive);
         rsp.right_forward = (right_drive >= 0);
         rsp.right_duty    = mag16(right_drive);
      end
   end

endmodule

// ----- rtl/core/dual_wheel_speed_pi_drive.sv -----
// Top level of the dual wheel speed PI drive: sequencer, registers, lanes and output word.
//
// One request word per control tick carries both encoder counts, the target
// speed, a base or offset drive and the mode. The block answers each request
// with exactly one response word: direction and duty of each wheel plus the
// filtered speed of each wheel.
// Both wheels run in two lanes side by side, each with its own multiplier,
// stepped together by one sequencer. Every lane step holds at most one multiply
// or one wide add and compare, so a word goes through 13 steps, the last of which
// loads the output register. A new request is taken only once the sequencer is
// back in idle, so a word is finished before the next one enters the lanes.
// The response sits in an output register; if the receiver stalls, the
// finished word waits there and the sequencer holds in its last step until
// the register frees, and only then takes the next request.
// Reset (synchronous) clears the encoder history, filters, accumulators and
// previous errors, and loads the default configuration registers. The user must
// write configuration registers over the APB-style port while idle; not enforced.
module dual_wheel_speed_pi_drive import dwsp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   step_type state_ff, state_in;

   req_type  req_ff, req_in;
   rsp_type  rsp_ff, rsp_in;
   rsp_type  merged;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     load_rsp;

   logic [8:0]  alpha_ff, alpha_in;
   logic [15:0] scale_ff, scale_in;
   logic [15:0] ki_l_ff, ki_l_in;
   logic [15:0] kp_l_ff, kp_l_in;
   logic [15:0] ki_r_ff, ki_r_in;
   logic [15:0] kp_r_ff, kp_r_in;
   logic [14:0] max_pwm_ff, max_pwm_in;

   logic                      csr_write;
   logic [2:0]                csr_index;
   logic signed [TGT_W:0]     tgt_abs;
   logic signed [TGT_W-1:0]   tgt_eff;
   lane_cfg_type              cfg_left;
   lane_cfg_type              cfg_right;
   logic signed [SPEED_W-1:0] left_spd;
   logic signed [SPEED_W-1:0] right_spd;
   logic signed [CTL_W-1:0]   left_ctl;
   logic signed [CTL_W-1:0]   right_ctl;

   // Configuration port: writes in the access cycle, reads return the register.
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = paddr[4:2];

   always_comb begin
      alpha_in   = alpha_ff;
      scale_in   = scale_ff;
      ki_l_in    = ki_l_ff;
      kp_l_in    = kp_l_ff;
      ki_r_in    = ki_r_ff;
      kp_r_in    = kp_r_ff;
      max_pwm_in = max_pwm_ff;
      if (csr_write) begin
         case (csr_index)
            REG_FILTER_ALPHA: alpha_in   = pwdata[8:0];
            REG_SPEED_SCALE:  scale_in   = pwdata[15:0];
            REG_KI_LEFT:      ki_l_in    = pwdata[15:0];
            REG_KP_LEFT:      kp_l_in    = pwdata[15:0];
            REG_KI_RIGHT:     ki_r_in    = pwdata[15:0];
            REG_KP_RIGHT:     kp_r_in    = pwdata[15:0];
            REG_MAX_PWM:      max_pwm_in = pwdata[14:0];
            default:          alpha_in   = alpha_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_FILTER_ALPHA: prdata = CSR_DATA_W'(alpha_ff);
         REG_SPEED_SCALE:  prdata = CSR_DATA_W'(scale_ff);
         REG_KI_LEFT:      prdata = CSR_DATA_W'(ki_l_ff);
         REG_KP_LEFT:      prdata = CSR_DATA_W'(kp_l_ff);
         REG_KI_RIGHT:     prdata = CSR_DATA_W'(ki_r_ff);
         REG_KP_RIGHT:     prdata = CSR_DATA_W'(kp_r_ff);
         REG_MAX_PWM:      prdata = CSR_DATA_W'(max_pwm_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff   <= 9'd77;
         scale_ff   <= 16'd256;
         ki_l_ff    <= 16'd1971;
         kp_l_ff    <= 16'd0;
         ki_r_ff    <= 16'd1920;
         kp_r_ff    <= 16'd0;
         max_pwm_ff <= 15'd10000;
      end else begin
         alpha_ff   <= alpha_in;
         scale_ff   <= scale_in;
         ki_l_ff    <= ki_l_in;
         kp_l_ff    <= kp_l_in;
         ki_r_ff    <= ki_r_in;
         kp_r_ff    <= kp_r_in;
         max_pwm_ff <= max_pwm_in;
      end
   end

   // Sequencer next state.
   always_comb begin
      case (state_ff)
         ST_IDLE:  state_in = req_valid ? ST_DELTA : ST_IDLE;
         ST_DELTA: state_in = ST_RAW;
         ST_RAW:   state_in = ST_AMUL;
         ST_AMUL:  state_in = ST_BMUL;
         ST_BMUL:  state_in = ST_FILT;
         ST_FILT:  state_in = ST_SPEED;
         ST_SPEED: state_in = ST_ERR;
         ST_ERR:   state_in = ST_IMUL;
         ST_IMUL:  state_in = ST_PMUL;
         ST_PMUL:  state_in = ST_INC;
         ST_INC:   state_in = ST_ACC;
         ST_ACC:   state_in = ST_CTL;
         ST_CTL:   state_in = ST_OUT;
         ST_OUT:   state_in = (!rsp_valid_ff || rsp_ready) ? ST_IDLE : ST_OUT;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_OUT:  load_rsp  = !rsp_valid_ff || rsp_ready;
         default: req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Request word held for the whole sequence.
   assign req_in = (req_valid && req_ready) ? req_data : req_ff;

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   // Speed mode ignores targets inside the deadband.
   always_comb begin
      tgt_abs = (req_ff.target < 0) ? -(TGT_W+1)'(req_ff.target)
                                    : (TGT_W+1)'(req_ff.target);
      if (!req_ff.command && tgt_abs < (TGT_W+1)'(DEADBAND)) begin
         tgt_eff = '0;
      end else begin
         tgt_eff = req_ff.target;
      end
   end

   assign cfg_left  = '{alpha: alpha_ff, scale: scale_ff, ki: ki_l_ff, kp: kp_l_ff,
                        max_pwm: max_pwm_ff};
   assign cfg_right = '{alpha: alpha_ff, scale: scale_ff, ki: ki_r_ff, kp: kp_r_ff,
                        max_pwm: max_pwm_ff};

   // Left and right wheel lanes.
   dwsp_lane u_lane_left (
      .clock     (clock),
      .reset     (reset),
      .step      (state_ff),
      .count     (req_ff.left_enc),
      .target    (tgt_eff),
      .cfg       (cfg_left),
      .speed_now (left_spd),
      .control   (left_ctl)
   );

   dwsp_lane u_lane_right (
      .clock     (clock),
      .reset     (reset),
      .step      (state_ff),
      .count     (req_ff.right_enc),
      .target    (tgt_eff),
      .cfg       (cfg_right),
      .speed_now (right_spd),
      .control   (right_ctl)
   );

   dwsp_merge u_merge (
      .command        (req_ff.command),
      .base_or_offset (req_ff.base_or_offset),
      .left_spd       (left_spd),
      .right_spd      (right_spd),
      .left_ctl       (left_ctl),
      .right_ctl      (right_ctl),
      .rsp            (merged)
   );

   // Output register between the sequencer and the receiver.
   always_comb begin
      rsp_in = load_rsp ? merged : rsp_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // An accepted request always starts the lane sequence.
   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_DELTA)
      else $error("accepted request did not start the sequence");

   // A finished word never leaves the last step while the output is blocked.
   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && rsp_valid_ff && !rsp_ready |=> state_ff == ST_OUT)
      else $error("finished word dropped while the output was stalled");

   // A new response only comes out of the last sequence step.
   a_rsp_from_out : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("response raised outside the output step");

   // Loading the output register always presents a valid word.
   a_load_valid : assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid_ff)
      else $error("output load did not raise valid");

endmodule

// ----- tb/dual_wheel_speed_pi_drive_tb.sv -----
// Self-checking testbench of the dual wheel speed PI drive, with its own prediction of each word.
module dual_wheel_speed_pi_drive_tb import dwsp_pkg::*; ();

   localparam int RUN_LIMIT = 2000000;
   localparam int LONG_HOLD = 600;
   localparam int PHASE_WORDS = 150;
   localparam longint I32_MIN = -64'sd2147483648;
   localparam longint I32_MAX = 64'sd2147483647;
   localparam longint SPD_MIN = -64'sd8388608;
   localparam longint SPD_MAX = 64'sd8388607;

   // Block ports; the inputs are driven to known values from time zero.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Predicted register contents, loaded with the reset defaults.
   logic [8:0]  alpha_q   = 9'd77;
   logic [15:0] scale_q   = 16'd256;
   logic [15:0] ki_q [2]  = '{16'd1971, 16'd1920};
   logic [15:0] kp_q [2]  = '{16'd0, 16'd0};
   logic [14:0] pwm_limit = 15'd10000;

   // Predicted per-wheel state; index 0 is the left wheel, 1 the right wheel.
   logic [31:0] prev_count [2] = '{32'd0, 32'd0};
   longint      speed_filt [2] = '{0, 0};
   longint      accum      [2] = '{0, 0};
   longint      prev_err   [2] = '{0, 0};

   // Response words still owed by the block, oldest first.
   rsp_type drive_due [$];
   int      fault_count = 0;

   // Knobs shared by the sender and the receiver.
   int      stall_pct = 0;
   logic    hold_long = 1'b0;
   logic    hold_taken = 1'b0;
   int      hold_cnt = 0;

   // Running encoder counts of the random ticks.
   logic [31:0] cnt_l = '0;
   logic [31:0] cnt_r = '0;

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type want;
   } plan_row_type;
   plan_row_type plan [$];

   dual_wheel_speed_pi_drive uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #RUN_LIMIT;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic longint sat(input longint x, input longint lo, input longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   // Move a value with 8 fractional bits to FRAC_BITS fractional bits, flooring.
   function automatic longint frac_of_q8(input longint x);
      return (FRAC_UP > 0) ? (x <<< FRAC_UP) : (x >>> FRAC_DN);
   endfunction

   // Integer part, truncated toward zero.
   function automatic longint to_int_tz(input longint x);
      if (x < 0) return -((-x) >>> FRAC_BITS);
      return x >>> FRAC_BITS;
   endfunction

   function automatic longint mag16(input longint v);
      if (v < 0) v = -v;
      return (v > 65535) ? 65535 : v;
   endfunction

   // Wrapping count delta, scaling and exponential smoothing of one wheel.
   function automatic longint filter_speed(input int w, input logic [31:0] count);
      logic signed [31:0] d;
      longint a, raw;
      d = count - prev_count[w];
      prev_count[w] = count;
      a = (alpha_q > 9'd256) ? 256 : longint'(alpha_q);
      raw = sat(frac_of_q8(longint'(d) * longint'(scale_q)), I32_MIN, I32_MAX);
      speed_filt[w] = sat((a * raw + (256 - a) * speed_filt[w]) >>> 8, I32_MIN, I32_MAX);
      return sat(to_int_tz(speed_filt[w]), SPD_MIN, SPD_MAX);
   endfunction

   // Incremental PI update of one wheel; returns the integer control value.
   function automatic longint pi_step(input int w, input longint tgt, input longint cur);
      longint err, lim, inc;
      err = tgt - cur;
      lim = longint'(pwm_limit) <<< FRAC_BITS;
      inc = frac_of_q8(longint'(ki_q[w]) * (err - prev_err[w]) + longint'(kp_q[w]) * err);
      prev_err[w] = err;
      accum[w] = sat(accum[w] + inc, -lim, lim);
      return to_int_tz(accum[w]);
   endfunction

   // Full response word of one control tick.
   function automatic rsp_type compute_drive(input req_type w);
      rsp_type r;
      longint tgt, bo, ls, rs, cl, cr, lv, rv;
      tgt = longint'($signed(w.target));
      bo = longint'($signed(w.base_or_offset));
      ls = filter_speed(0, w.left_enc);
      rs = filter_speed(1, w.right_enc);
      // Speed mode ignores small targets.
      if (!w.command && tgt > -DEADBAND && tgt < DEADBAND) tgt = 0;
      cl = pi_step(0, tgt, ls);
      cr = pi_step(1, tgt, rs);
      if (w.command) begin
         rv = bo + ((cr < 0) ? -cr : cr);
         r.left_forward = (cl > 0);
         r.left_duty = '0;
         r.right_forward = (cr > 0);
         r.right_duty = (rv < 0) ? '0 : DUTY_W'(mag16(rv));
      end else begin
         lv = bo - cl;
         rv = bo + cr;
         r.left_forward = (lv >= 0);
         r.left_duty = DUTY_W'(mag16(lv));
         r.right_forward = (rv >= 0);
         r.right_duty = DUTY_W'(mag16(rv));
      end
      r.left_speed_now = SPEED_W'(ls);
      r.right_speed_now = SPEED_W'(rs);
      return r;
   endfunction

   function automatic rsp_type duty_word(input bit lf, input int ld, input bit rf, input int rd);
      rsp_type r;
      r = '0;
      r.left_forward = lf;
      r.left_duty = DUTY_W'(ld);
      r.right_forward = rf;
      r.right_duty = DUTY_W'(rd);
      return r;
   endfunction

   task automatic add_row(input bit cmd, input logic [31:0] lc, input logic [31:0] rc,
                          input int tgt, input int bo, input bit typed, input rsp_type want);
      plan_row_type row;
      row.word.command = cmd;
      row.word.left_enc = lc;
      row.word.right_enc = rc;
      row.word.target = TGT_W'(tgt);
      row.word.base_or_offset = 16'(bo);
      row.typed = typed;
      row.want = want;
      plan.push_back(row);
   endtask

   task automatic flag(input string name, input logic signed [31:0] exp_v,
                       input logic signed [31:0] act_v);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fault_count++;
   endtask

   // Compare one response word against the oldest owed word.
   task automatic check_drive(input rsp_type got);
      rsp_type want;
      if (drive_due.size() == 0) begin
         $display("%0t: response word %h with nothing owed", $time, got);
         fault_count++;
         return;
      end
      want = drive_due.pop_front();
      if (got.left_forward !== want.left_forward)
         flag("left_forward", want.left_forward, got.left_forward);
      if (got.left_duty !== want.left_duty)
         flag("left_duty", want.left_duty, got.left_duty);
      if (got.right_forward !== want.right_forward)
         flag("right_forward", want.right_forward, got.right_forward);
      if (got.right_duty !== want.right_duty)
         flag("right_duty", want.right_duty, got.right_duty);
      if (got.left_speed_now !== want.left_speed_now)
         flag("left_speed_now", want.left_speed_now, got.left_speed_now);
      if (got.right_speed_now !== want.right_speed_now)
         flag("right_speed_now", want.right_speed_now, got.right_speed_now);
   endtask

   // Offer one request word, wait for it to be taken, then maybe idle for a while.
   task automatic feed(input req_type w, input bit typed, input rsp_type want);
      rsp_type due;
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      due = compute_drive(w);
      drive_due.push_back(typed ? want : due);
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every owed word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (drive_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // APB write: setup cycle, access cycle, then the port is left idle.
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_FILTER_ALPHA: alpha_q = val[8:0];
         REG_SPEED_SCALE:  scale_q = val[15:0];
         REG_KI_LEFT:      ki_q[0] = val[15:0];
         REG_KP_LEFT:      kp_q[0] = val[15:0];
         REG_KI_RIGHT:     ki_q[1] = val[15:0];
         REG_KP_RIGHT:     kp_q[1] = val[15:0];
         REG_MAX_PWM:      pwm_limit = val[14:0];
         default: ;
      endcase
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_gains(input logic [31:0] alpha, input logic [31:0] scale,
                             input logic [31:0] kil, input logic [31:0] kpl,
                             input logic [31:0] kir, input logic [31:0] kpr,
                             input logic [31:0] pwm);
      csr_write(REG_FILTER_ALPHA, alpha);
      csr_write(REG_SPEED_SCALE, scale);
      csr_write(REG_KI_LEFT, kil);
      csr_write(REG_KP_LEFT, kpl);
      csr_write(REG_KI_RIGHT, kir);
      csr_write(REG_KP_RIGHT, kpr);
      csr_write(REG_MAX_PWM, pwm);
   endtask

   // Random control tick: mostly plausible encoder motion, some slips and pure noise.
   function automatic req_type roll_tick();
      req_type w;
      int pick, t, b;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         cnt_l = cnt_l + 32'($urandom_range(0, 600) - 300);
         cnt_r = cnt_r + 32'($urandom_range(0, 600) - 300);
         w.command = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 3) == 0) t = $urandom_range(0, 12) - 6;
         else t = $urandom_range(0, 4000) - 2000;
         b = $urandom_range(0, 6000) - 3000;
      end else if (pick < 90) begin
         cnt_l = cnt_l + 32'($urandom_range(0, 2097152) - 1048576);
         cnt_r = cnt_r + 32'($urandom_range(0, 2097152) - 1048576);
         w.command = ($urandom_range(0, 1) == 0);
         t = $urandom_range(0, 65535);
         b = $urandom_range(0, 65535);
      end else begin
         cnt_l = $urandom;
         cnt_r = $urandom;
         w.command = ($urandom_range(0, 1) == 0);
         t = $urandom_range(0, 65535);
         b = $urandom_range(0, 65535);
      end
      w.left_enc = cnt_l;
      w.right_enc = cnt_r;
      w.target = TGT_W'(t);
      w.base_or_offset = 16'(b);
      return w;
   endfunction

   // Receiver: check each accepted word, then choose ready for the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_drive(rsp_data);
         if (hold_long && !hold_taken) begin
            hold_taken = 1'b1;
            hold_cnt = LONG_HOLD;
         end else if (hold_cnt == 0 && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            hold_cnt = $urandom_range(1, 14);
         end
         if (hold_cnt > 0) begin
            rsp_ready <= 1'b0;
            hold_cnt = hold_cnt - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Sender: directed table, then configuration phases with random ticks.
   initial begin
      int ph, i, k;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero state and default gains: these words can be read straight off.
      add_row(1'b0, 32'h0, 32'h0, 0, 0, 1'b1, duty_word(1'b1, 0, 1'b1, 0));
      add_row(1'b0, 32'h0, 32'h0, 0, 32767, 1'b1, duty_word(1'b1, 32767, 1'b1, 32767));
      add_row(1'b0, 32'h0, 32'h0, 0, -32768, 1'b1, duty_word(1'b0, 32768, 1'b0, 32768));
      add_row(1'b0, 32'h0, 32'h0, 4, 100, 1'b1, duty_word(1'b1, 100, 1'b1, 100));
      add_row(1'b0, 32'h0, 32'h0, -4, -1, 1'b1, duty_word(1'b0, 1, 1'b0, 1));
      add_row(1'b1, 32'h0, 32'h0, 0, -5, 1'b1, duty_word(1'b0, 0, 1'b0, 0));
      add_row(1'b1, 32'h0, 32'h0, 0, 32767, 1'b1, duty_word(1'b0, 0, 1'b0, 32767));
      // Deadband edges, turn mode without deadband, wrapping counts, field extremes.
      add_row(1'b0, 32'h0, 32'h0, 5, 0, 1'b0, '0);
      add_row(1'b0, 32'h0, 32'h0, -5, 0, 1'b0, '0);
      add_row(1'b1, 32'h0, 32'h0, 3, 0, 1'b0, '0);
      add_row(1'b0, 32'd100, 32'd100, 200, 1000, 1'b0, '0);
      add_row(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32767, 0, 1'b0, '0);
      add_row(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, -32768, 32767, 1'b0, '0);
      add_row(1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 32767, -32768, 1'b0, '0);
      add_row(1'b1, 32'h0, 32'h0, -32768, 32767, 1'b0, '0);
      add_row(1'b0, 32'h0, 32'h0, 0, 0, 1'b0, '0);
      add_row(1'b1, 32'h0000_ABCD, 32'hFFFF_5433, 1234, -1234, 1'b0, '0);
      add_row(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 21845, -21846, 1'b0, '0);
      for (k = 0; k < plan.size(); k++) feed(plan[k].word, plan[k].typed, plan[k].want);
      drain();

      for (ph = 1; ph <= 9; ph++) begin
         // Register settings of this phase: extremes first, then random ones, the defaults last.
         case (ph)
            1: load_gains(256, 65535, 65535, 65535, 65535, 65535, 32767);
            2: load_gains(0, 0, 0, 0, 0, 0, 0);
            3: load_gains(511, 256, 1971, 300, 1920, 300, 10000);
            8: load_gains($urandom_range(0, 511), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 32767));
            9: load_gains(77, 256, 1971, 0, 1920, 0, 10000);
            default: load_gains($urandom_range(0, 256), $urandom_range(16, 2048),
                                $urandom_range(0, 8000), $urandom_range(0, 3000),
                                $urandom_range(0, 8000), $urandom_range(0, 3000),
                                $urandom_range(50, 32767));
         endcase
         if (ph == 3) begin
            cnt_l = 32'h7FFF_FF00;
            cnt_r = 32'h8000_0100;
         end
         if (ph == 9) stall_pct <= 0;
         for (i = 0; i < PHASE_WORDS; i++) begin
            // Idling comes in stretches: none, light or heavy.
            if (ph != 9 && i % 40 == 0) begin
               case ($urandom_range(0, 2))
                  0: stall_pct <= 0;
                  1: stall_pct <= 10;
                  default: stall_pct <= 35;
               endcase
            end
            // The receiver holds off long enough to back up the input side.
            if (ph == 4 && i == 20) hold_long <= 1'b1;
            // The sender pauses until every owed word has come back.
            if (ph == 4 && i == 100) drain();
            feed(roll_tick(), 1'b0, '0);
         end
         drain();
      end

      if (fault_count == 0 && drive_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/dwsp_pkg.sv
rtl/core/dwsp_lane.sv
rtl/core/dwsp_merge.sv
rtl/core/dual_wheel_speed_pi_drive.sv
tb/dual_wheel_speed_pi_drive_tb.sv
